// ===== rtl/core/bdg_pkg.sv =====
// Package for the button debounce and gesture detector.
// Holds the configuration record, register indexes and gesture codes.
// No dependencies.
package bdg_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned IntegW = 8;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    REG_INVERT_INPUT  = 2'd0,
    REG_DEBOUNCE_LIM  = 2'd1,
    REG_LONG_PRESS    = 2'd2,
    REG_DOUBLE_WINDOW = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GESTURE_NONE   = 2'd0,
    GESTURE_SINGLE = 2'd1,
    GESTURE_DOUBLE = 2'd2,
    GESTURE_LONG   = 2'd3
  } gesture_e;

  localparam logic              InvertReset   = 1'b1;
  localparam logic [IntegW-1:0] DebounceReset = 8'd4;
  localparam logic [MsW-1:0]    LongReset     = 16'd1200;
  localparam logic [MsW-1:0]    DoubleReset   = 16'd300;

  typedef struct packed {
    logic              invert_input;
    logic [IntegW-1:0] debounce_limit;
    logic [MsW-1:0]    long_press_time;
    logic [MsW-1:0]    double_window_time;
  } bdg_cfg_t;

endpackage

// ===== rtl/core/bdg_cfg_regs.sv =====
// Configuration registers of the button debounce and gesture detector.
// Depends on bdg_pkg for the register indexes and the configuration record.
module bdg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdg_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bdg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bdg_pkg::bdg_cfg_t             cfg_o
);
  import bdg_pkg::*;

  bdg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_INVERT_INPUT:  cfg_d.invert_input       = cfg_wdata_i[0];
        REG_DEBOUNCE_LIM:  cfg_d.debounce_limit     = cfg_wdata_i[IntegW-1:0];
        REG_LONG_PRESS:    cfg_d.long_press_time    = cfg_wdata_i[MsW-1:0];
        REG_DOUBLE_WINDOW: cfg_d.double_window_time = cfg_wdata_i[MsW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert_input       <= InvertReset;
      cfg_q.debounce_limit     <= DebounceReset;
      cfg_q.long_press_time    <= LongReset;
      cfg_q.double_window_time <= DoubleReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bdg_gesture.sv =====
// Debounce integrator and gesture state for one scan tick per cycle.
// Depends on bdg_pkg; state advances only when step_i is high.
module bdg_gesture (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bdg_pkg::bdg_cfg_t           cfg_i,
  input  logic                        step_i,
  input  logic                        level_i,
  input  logic [bdg_pkg::TimeW-1:0]   now_i,
  output bdg_pkg::gesture_e           gesture_o,
  output logic                        pressed_o
);
  import bdg_pkg::*;

  logic              stable_q, stable_d;
  logic [IntegW-1:0] integ_q, integ_d;
  logic [TimeW-1:0]  press_start_q, press_start_d;
  logic              long_rep_q, long_rep_d;
  logic              awaiting_q, awaiting_d;
  logic [TimeW-1:0]  first_rel_q, first_rel_d;

  logic             sample;
  logic             rise, fall;
  logic [TimeW-1:0] diff_press, diff_first;
  logic             long_hit;
  logic             first_moved;
  logic             check_single;
  gesture_e         gesture;

  assign sample     = level_i ^ cfg_i.invert_input;
  assign diff_press = now_i - press_start_q;
  assign diff_first = now_i - first_rel_q;

  always_comb begin
    integ_d = integ_q;
    if (sample) begin
      if (integ_q < cfg_i.debounce_limit) integ_d = integ_q + IntegW'(1);
    end else if (integ_q != '0) begin
      integ_d = integ_q - IntegW'(1);
    end
  end

  assign rise     = (integ_d == cfg_i.debounce_limit) && !stable_q;
  assign fall     = !rise && (integ_d == '0) && stable_q;
  assign stable_d = rise ? 1'b1 : (fall ? 1'b0 : stable_q);

  // On the press edge itself the elapsed time is zero.
  assign long_hit = stable_d && (rise || !long_rep_q) &&
                    ((rise ? '0 : diff_press) >= TimeW'(cfg_i.long_press_time));

  always_comb begin
    press_start_d = rise ? now_i : press_start_q;
    long_rep_d    = rise ? 1'b0 : long_rep_q;
    awaiting_d    = awaiting_q;
    first_rel_d   = first_rel_q;
    first_moved   = 1'b0;
    check_single  = 1'b1;
    gesture       = GESTURE_NONE;

    if (long_hit) begin
      long_rep_d = 1'b1;
      awaiting_d = 1'b0;
      gesture    = GESTURE_LONG;
    end

    if (fall) begin
      if (long_rep_q) begin
        check_single = 1'b0;
      end else if (awaiting_q) begin
        if (diff_first <= TimeW'(cfg_i.double_window_time)) begin
          awaiting_d = 1'b0;
          gesture    = GESTURE_DOUBLE;
        end else begin
          first_rel_d = now_i;
          first_moved = 1'b1;
        end
      end else begin
        awaiting_d  = 1'b1;
        first_rel_d = now_i;
        first_moved = 1'b1;
      end
    end

    // A window restarted on this tick has zero elapsed time and cannot expire.
    if (check_single && awaiting_d && !stable_d && !first_moved &&
        (diff_first > TimeW'(cfg_i.double_window_time))) begin
      awaiting_d = 1'b0;
      gesture    = GESTURE_SINGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q      <= 1'b0;
      integ_q       <= '0;
      press_start_q <= '0;
      long_rep_q    <= 1'b0;
      awaiting_q    <= 1'b0;
      first_rel_q   <= '0;
    end else if (step_i) begin
      stable_q      <= stable_d;
      integ_q       <= integ_d;
      press_start_q <= press_start_d;
      long_rep_q    <= long_rep_d;
      awaiting_q    <= awaiting_d;
      first_rel_q   <= first_rel_d;
    end
  end

  assign gesture_o = gesture;
  assign pressed_o = stable_d;

  a_long_only_pressed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && gesture == GESTURE_LONG) |-> stable_d)
    else $error("long press reported while released");

  a_click_only_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (gesture == GESTURE_SINGLE || gesture == GESTURE_DOUBLE)) |-> !stable_d)
    else $error("click reported while pressed");

  a_long_sets_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && gesture == GESTURE_LONG) |=> (long_rep_q && !awaiting_q))
    else $error("long press did not mark the hold as reported");

  a_double_clears_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && gesture == GESTURE_DOUBLE) |=> !awaiting_q)
    else $error("double press left a pending second release");

endmodule

// ===== rtl/core/button_debounce_gesture_detector.sv =====
// Top level of the button debounce and gesture detector.
// Depends on bdg_pkg, bdg_cfg_regs and bdg_gesture.
//
// Usage:
//   Each request on the input channel is one scan tick: raw_level_i and a
//   millisecond timestamp time_ms_i. Every request gives exactly one result on
//   the output channel: the gesture code (none, single, double, long) and the
//   debounced pressed state after that tick.
//   A request accepted into the input register waits there until the result
//   register is free or being taken; then the debounce and gesture logic
//   updates its state and loads the result register with that tick's result.
//   Throughput is one request per cycle while out_ready_i stays high: the
//   state update is a single pass of compares and small adds between the
//   input and result registers.
//   When the receiver stalls, the result register holds its item, the input
//   register holds the next one, and in_ready_o drops once both are full.
//   Reset clears the pipeline valids and the gesture state (released, no
//   pending click) and loads the register defaults: inverted input, debounce
//   limit 4, long press 1200 ms, double window 300 ms.
//   Configuration writes take effect at the next edge and are expected only
//   while no request is in flight.
module button_debounce_gesture_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdg_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bdg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          raw_level_i,
  input  logic [bdg_pkg::TimeW-1:0]     time_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    gesture_o,
  output logic                          pressed_state_o
);
  import bdg_pkg::*;

  bdg_cfg_t cfg;

  logic             in_valid_q, in_valid_d;
  logic             level_q;
  logic [TimeW-1:0] time_q;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       gesture_q;
  logic             pressed_q;
  logic             step;
  gesture_e         gesture;
  logic             pressed;

  bdg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  bdg_gesture u_gesture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .level_i   (level_q),
    .now_i     (time_q),
    .gesture_o (gesture),
    .pressed_o (pressed)
  );

  assign in_valid_d  = (in_valid_i && in_ready_o) ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q <= raw_level_i;
      time_q  <= time_ms_i;
    end
    if (step) begin
      gesture_q <= gesture;
      pressed_q <= pressed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gesture_o       = gesture_q;
  assign pressed_state_o = pressed_q;

  a_stall_blocks_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !step)
    else $error("result overwritten while the receiver stalls");

  a_full_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request accepted with both stages full");

  a_step_loads_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed tick did not produce a result");

endmodule
